// File: src/cax_pkg.sv
// ----------------------------------------------------------------------------
// cax_pkg
// Shared types and codes of the chained accumulator ALU.
// ----------------------------------------------------------------------------
package cax_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [3:0] CMD_LOAD = 4'd0;
  localparam logic [3:0] CMD_ADD  = 4'd1;
  localparam logic [3:0] CMD_SUB  = 4'd2;
  localparam logic [3:0] CMD_MUL  = 4'd3;
  localparam logic [3:0] CMD_DIV  = 4'd4;
  localparam logic [3:0] CMD_MOD  = 4'd5;
  localparam logic [3:0] CMD_POW  = 4'd6;
  localparam logic [3:0] CMD_XOR  = 4'd7;
  localparam logic [3:0] CMD_AND  = 4'd8;
  localparam logic [3:0] CMD_OR   = 4'd9;
  localparam logic [3:0] CMD_SHR  = 4'd10;
  localparam logic [3:0] CMD_SHL  = 4'd11;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_DIV0  = 2'd1;
  localparam logic [1:0] FAULT_SHIFT = 2'd2;
  localparam logic [1:0] FAULT_POW   = 2'd3;

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_POS  = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic REG_TARGET = 1'b0;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [63:0] operand;
    logic               end_of_chain;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] running_value;
    logic [63:0]        target_distance;
    logic [1:0]         fault_code;
    logic               chain_done;
  } out_item_t;

  // classified request as it waits in the queue
  typedef struct packed {
    logic [3:0]  cmd;
    logic [63:0] opnd;
    logic        eoc;
    logic        opnd_zero;
    logic        opnd_hi;   // some bit above bit 5 set
  } job_t;

endpackage

// File: src/chained_accumulator_alu_core.sv
// ----------------------------------------------------------------------------
// chained_accumulator_alu_core
// Top level: configuration register, front, request queue, execution side.
// ----------------------------------------------------------------------------
// Folds (command, operand) requests into a 64-bit signed accumulator and
// returns one result per request with the distance to target_value. Load,
// add, sub, logic ops and shifts are computed when the request is taken; mul
// runs on the shared 32 x 32 multiplier (4 partial products); div and mod
// run in the one-bit-per-cycle divider; pow makes at most twelve passes
// through the multiplier. The queue lets new requests in while one
// executes. target_value is at byte address 0 of the 64-bit register port
// and must only be written while the block is idle.
module chained_accumulator_alu_core #(
  parameter int unsigned QUEUE_DEPTH = cax_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cax_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output cax_pkg::out_item_t out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import cax_pkg::*;

  logic [63:0] target;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_not_empty;
  job_t        wr_job;
  job_t        rd_job;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_TARGET) ? target : 64'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '0;
    end else if (psel && penable && pwrite && (paddr[3] == REG_TARGET)) begin
      target <= pwdata;
    end
  end

  cax_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (wr_job)
  );

  cax_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_job    (wr_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_job    (rd_job)
  );

  cax_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_job       (rd_job),
    .q_pop       (q_pop),
    .target      (target),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

// File: src/cax_front.sv
// ----------------------------------------------------------------------------
// cax_front
// Accepts requests and classifies the operand for the execution side.
// ----------------------------------------------------------------------------
module cax_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  cax_pkg::in_item_t  in_item,
  input  logic               q_full,
  output logic               q_push,
  output cax_pkg::job_t      q_job
);
  import cax_pkg::*;

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  always_comb begin
    q_job.cmd       = in_item.command;
    q_job.opnd      = in_item.operand;
    q_job.eoc       = in_item.end_of_chain;
    q_job.opnd_zero = (in_item.operand == 64'sd0);
    q_job.opnd_hi   = |in_item.operand[63:6];
  end

endmodule

// File: src/cax_queue.sv
// ----------------------------------------------------------------------------
// cax_queue
// Short register queue between the front and the execution side.
// ----------------------------------------------------------------------------
module cax_queue #(
  parameter int unsigned DEPTH = cax_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cax_pkg::job_t wr_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output cax_pkg::job_t rd_job
);
  import cax_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/cax_mul.sv
// ----------------------------------------------------------------------------
// cax_mul
// 64 x 64 unsigned multiplier giving the full 128-bit product, built from
// one 32 x 32 partial product per cycle.
// ----------------------------------------------------------------------------
module cax_mul (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic          done,
  output logic [127:0]  prod
);

  logic [63:0]  ra;
  logic [63:0]  rb;
  logic         busy;
  logic [2:0]   step;
  logic [63:0]  pp;
  logic [1:0]   psh;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [127:0] pp_shifted;

  // step order: lo*lo, lo*hi, hi*lo, hi*hi
  assign pa = step[1] ? ra[63:32] : ra[31:0];
  assign pb = step[0] ? rb[63:32] : rb[31:0];

  always_comb begin
    case (psh)
      2'd1:    pp_shifted = {32'd0, pp, 32'd0};
      2'd2:    pp_shifted = {pp, 64'd0};
      default: pp_shifted = {64'd0, pp};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ra   <= a;
        rb   <= b;
        busy <= 1'b1;
        step <= '0;
        prod <= '0;
      end else if (busy) begin
        if (step != 3'd4) begin
          pp  <= {32'd0, pa} * {32'd0, pb};
          psh <= {1'b0, step[1]} + {1'b0, step[0]};
        end
        if (step != 3'd0) begin
          prod <= prod + pp_shifted;
        end
        if (step == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

endmodule

// File: src/cax_back.sv
// ----------------------------------------------------------------------------
// cax_back
// Execution side: holds the accumulator, runs the shared multiplier, the
// bit-serial divider and the power sequencer, and drives the result register.
// ----------------------------------------------------------------------------
module cax_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  cax_pkg::job_t      q_job,
  output logic               q_pop,
  input  logic [63:0]        target,
  output logic               out_valid,
  input  logic               out_stall,
  output cax_pkg::out_item_t out_item
);
  import cax_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_POW, S_FIN} state_t;

  state_t        state;
  logic [63:0]   acc;
  logic [63:0]   res;
  logic [1:0]    fault;
  logic [3:0]    jcmd;
  logic          jeoc;
  logic          aneg;
  logic          bneg;
  logic [63:0]   dvs;
  logic [63:0]   quo;
  logic [63:0]   rem;
  logic [6:0]    cnt;
  logic [63:0]   pr;
  logic [63:0]   pmag;
  logic [5:0]    pexp;
  logic [2:0]    pbit;
  logic          psq;
  logic          prneg;
  logic          mstart;
  logic [63:0]   ma;
  logic [63:0]   mb;
  logic          mdone;
  logic [127:0]  mprod;

  logic [63:0]   b;
  logic [63:0]   amag;
  logic [63:0]   bmag;
  logic          rneg_in;
  logic [64:0]   trial;
  logic          povf;
  logic [63:0]   psat;
  logic [63:0]   pr_new;
  logic          t_ge;

  cax_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mstart),
    .a     (ma),
    .b     (mb),
    .done  (mdone),
    .prod  (mprod)
  );

  assign b       = q_job.opnd;
  assign amag    = acc[63] ? (64'd0 - acc) : acc;
  assign bmag    = b[63] ? (64'd0 - b) : b;
  assign rneg_in = acc[63] & b[0];
  assign q_pop   = q_not_empty && (state == S_IDLE) && !out_valid;
  assign trial   = {rem, quo[63]} - {1'b0, dvs};
  assign psat    = prneg ? SIGN_BIT : MAX_POS;
  assign povf    = (|mprod[127:64]) || (mprod[63:0] > psat);
  assign pr_new  = mprod[63:0];
  assign t_ge    = $signed(target) >= $signed(res);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc       <= '0;
      out_valid <= 1'b0;
      mstart    <= 1'b0;
    end else begin
      mstart <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            jcmd  <= q_job.cmd;
            jeoc  <= q_job.eoc;
            aneg  <= acc[63];
            bneg  <= b[63];
            fault <= FAULT_NONE;
            res   <= acc;
            state <= S_FIN;
            case (q_job.cmd)
              CMD_LOAD: res <= b;
              CMD_ADD:  res <= acc + b;
              CMD_SUB:  res <= acc - b;
              CMD_XOR:  res <= acc ^ b;
              CMD_AND:  res <= acc & b;
              CMD_OR:   res <= acc | b;
              CMD_MUL: begin
                mstart <= 1'b1;
                ma     <= acc;
                mb     <= b;
                state  <= S_MUL;
              end
              CMD_DIV, CMD_MOD: begin
                if (q_job.opnd_zero) begin
                  fault <= FAULT_DIV0;
                end else begin
                  quo   <= amag;
                  rem   <= '0;
                  dvs   <= bmag;
                  cnt   <= '0;
                  state <= S_DIV;
                end
              end
              CMD_POW: begin
                prneg <= rneg_in;
                if (q_job.opnd_zero) begin
                  res <= 64'd1;
                end else if (b[63]) begin
                  if (amag == 64'd0) begin
                    res   <= MAX_POS;
                    fault <= FAULT_POW;
                  end else if (amag == 64'd1) begin
                    res <= rneg_in ? '1 : 64'd1;
                  end else begin
                    res <= '0;
                  end
                end else if (amag == 64'd0) begin
                  res <= '0;
                end else if (amag == 64'd1) begin
                  res <= rneg_in ? '1 : 64'd1;
                end else if (q_job.opnd_hi) begin
                  res   <= rneg_in ? SIGN_BIT : MAX_POS;
                  fault <= FAULT_POW;
                end else begin
                  // square and multiply from bit 5 down
                  pmag   <= amag;
                  pexp   <= b[5:0];
                  pr     <= 64'd1;
                  pbit   <= 3'd5;
                  psq    <= 1'b1;
                  mstart <= 1'b1;
                  ma     <= 64'd1;
                  mb     <= 64'd1;
                  state  <= S_POW;
                end
              end
              CMD_SHR, CMD_SHL: begin
                if (q_job.opnd_hi) begin
                  fault <= FAULT_SHIFT;
                end else if (q_job.cmd == CMD_SHL) begin
                  res <= acc << b[5:0];
                end else begin
                  res <= $unsigned($signed(acc) >>> b[5:0]);
                end
              end
              default: res <= acc;
            endcase
          end
        end
        S_MUL: begin
          if (mdone) begin
            res   <= mprod[63:0];
            state <= S_FIN;
          end
        end
        S_DIV: begin
          if (cnt == 7'd64) begin
            if (jcmd == CMD_DIV) begin
              res <= (aneg ^ bneg) ? (64'd0 - quo) : quo;
            end else begin
              res <= aneg ? (64'd0 - rem) : rem;
            end
            state <= S_FIN;
          end else begin
            if (!trial[64]) begin
              rem <= trial[63:0];
              quo <= {quo[62:0], 1'b1};
            end else begin
              rem <= {rem[62:0], quo[63]};
              quo <= {quo[62:0], 1'b0};
            end
            cnt <= cnt + 1'b1;
          end
        end
        S_POW: begin
          if (mdone) begin
            if (povf) begin
              res   <= psat;
              fault <= FAULT_POW;
              state <= S_FIN;
            end else begin
              pr <= pr_new;
              if (psq && pexp[pbit]) begin
                psq    <= 1'b0;
                mstart <= 1'b1;
                ma     <= pr_new;
                mb     <= pmag;
              end else if (pbit == 3'd0) begin
                res   <= prneg ? (64'd0 - pr_new) : pr_new;
                state <= S_FIN;
              end else begin
                pbit   <= pbit - 1'b1;
                psq    <= 1'b1;
                mstart <= 1'b1;
                ma     <= pr_new;
                mb     <= pr_new;
              end
            end
          end
        end
        S_FIN: begin
          acc                      <= res;
          out_item.running_value   <= res;
          out_item.target_distance <= t_ge ? (target - res) : (res - target);
          out_item.fault_code      <= fault;
          out_item.chain_done      <= jeoc;
          out_valid                <= 1'b1;
          state                    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE) && !out_valid)
    else $error("request taken while result register busy");

  a_fin_fills_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> out_valid)
    else $error("finished request did not reach result register");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cnt <= 7'd64))
    else $error("divider step count overrun");

  a_mul_single: assert property (@(posedge clk) disable iff (rst)
    mstart |=> !mstart)
    else $error("multiplier restarted while busy");

endmodule
